>>> design/life_generation_engine_assert.svh
// ----------------------------------------------------------------------------
// life_generation_engine_assert.svh
// Assertion macros shared by the life generation engine modules.
// ----------------------------------------------------------------------------
`ifndef LIFE_GENERATION_ENGINE_ASSERT_SVH
`define LIFE_GENERATION_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS
// Property checked on every clock edge outside reset.
`define LGE_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: assertion failed");
// Same-cycle implication, antecedent and consequent given separately.
`define LGE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: implication failed");
`else
`define LGE_ASSERT(label, clk, rst_n, prop)
`define LGE_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`endif

`endif

>>> design/lge_pkg.sv
// ----------------------------------------------------------------------------
// lge_pkg
// Shared constants, codes and control types of the life generation engine.
// ----------------------------------------------------------------------------
package lge_pkg;

  localparam int unsigned DEF_MAX_WIDTH  = 64;
  localparam int unsigned DEF_MAX_HEIGHT = 64;

  localparam int unsigned COORD_W   = 6;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned CFG_W     = 7;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned COUNT_W   = 13;

  localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
  localparam logic [CFG_W-1:0]   GRID_RESET = 7'd64;

  // item kinds
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
  localparam logic [KIND_W-1:0] KIND_GEN   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'd1;

  // Moore neighborhood offsets
  localparam int NBR_DX [8] = '{-1, 0, 1, -1, 1, -1, 0, 1};
  localparam int NBR_DY [8] = '{-1, -1, -1, 0, 0, 1, 1, 1};

  typedef struct packed {
    logic accept;
    logic cell_wr;
    logic cell_rd;
    logic sweep_start;
    logic clear_en;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic sweep_done;
  } status_t;

endpackage

>>> design/lge_ctrl.sv
// ----------------------------------------------------------------------------
// lge_ctrl
// Sequencer: handshakes, item decode, clearing pass and generation control.
// ----------------------------------------------------------------------------
module lge_ctrl
  import lge_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [KIND_W-1:0] kind_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output cmd_t              cmd_o,
  input  status_t           status_i
);

`include "life_generation_engine_assert.svh"

  typedef enum logic [3:0] {
    ST_CLEAR = 4'b0001,
    ST_IDLE  = 4'b0010,
    ST_SWEEP = 4'b0100,
    ST_POST  = 4'b1000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   out_free;
  logic   is_wr, is_rd, is_gen;

  always_comb begin
    is_wr  = 1'b0;
    is_rd  = 1'b0;
    is_gen = 1'b0;
    unique case (kind_i)
      KIND_WRITE: is_wr = 1'b1;
      KIND_GEN:   is_gen = 1'b1;
      KIND_READ:  is_rd = 1'b1;
      default:    ;
    endcase
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  // result register can take a new beat
  assign out_free   = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o.accept      = accept;
    cmd_o.cell_wr     = accept && is_wr;
    cmd_o.cell_rd     = accept && is_rd;
    cmd_o.sweep_start = accept && is_gen;
    cmd_o.clear_en    = (state_q == ST_CLEAR);
    cmd_o.out_load    = (state_q == ST_POST) && out_free;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (status_i.clear_done) state_d = ST_IDLE;
      ST_IDLE: begin
        if (accept) state_d = is_gen ? ST_SWEEP : ST_POST;
      end
      ST_SWEEP: if (status_i.sweep_done) state_d = ST_POST;
      ST_POST:  if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  `LGE_ASSERT_IMPL(a_load_only_when_free, clk_i, rst_ni, cmd_o.out_load, out_free)
  `LGE_ASSERT_IMPL(a_sweep_done_in_sweep, clk_i, rst_ni, status_i.sweep_done, state_q == ST_SWEEP)
  `LGE_ASSERT(a_no_accept_while_clearing, clk_i, rst_ni, cmd_o.clear_en |-> !cmd_o.accept)

endmodule

>>> design/lge_dp.sv
// ----------------------------------------------------------------------------
// lge_dp
// Datapath: two cell banks, raster sweep with a line-buffer window, B3/S23
// update, generation counters, configuration and result registers.
// ----------------------------------------------------------------------------
module lge_dp
  import lge_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  output status_t              status_o,
  input  logic [COORD_W-1:0]   cell_x_i,
  input  logic [COORD_W-1:0]   cell_y_i,
  input  logic                 cell_value_i,
  input  logic                 cfg_valid_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  output logic                 read_value_o,
  output logic [COUNT_W-1:0]   change_count_o,
  output logic [COUNT_W-1:0]   alive_count_o
);

`include "life_generation_engine_assert.svh"

  localparam int unsigned NCELL  = MAX_WIDTH * MAX_HEIGHT;
  localparam int unsigned AW     = $clog2(NCELL);
  localparam int unsigned CW     = AW + 1;
  localparam int unsigned XW     = $clog2(MAX_WIDTH);
  localparam int unsigned YW     = $clog2(MAX_HEIGHT);
  localparam int unsigned SR_LEN = 2 * MAX_WIDTH + 3;
  localparam int unsigned S_LAST = NCELL + MAX_WIDTH;
  localparam int unsigned S_EMIT = MAX_WIDTH + 1;
  localparam int unsigned CENTER = MAX_WIDTH + 1;

  // configuration
  logic [CFG_W-1:0] grid_width_q, grid_height_q;

  // banks
  logic mem_a_q [NCELL];
  logic mem_b_q [NCELL];
  logic rdata_a_q, rdata_b_q;
  logic cur_q;

  // read stage of the sweep
  logic          rd_run_q;
  logic [CW-1:0] s_q;
  logic [XW-1:0] sx_q;
  logic [YW-1:0] sy_q;
  logic          pad_a, inarea_a;

  // shift stage
  logic              vb_q, inb_q, emitb_q;
  logic [SR_LEN-1:0] sr_q;
  logic              src_bit;

  // update stage
  logic          win_v_q;
  logic [AW-1:0] c_idx_q;
  logic [XW-1:0] cx_q;
  logic [YW-1:0] cy_q;
  logic          sweep_last_q;
  logic [7:0]    nb;
  logic [3:0]    nsum;
  logic          cur_c, cin, next_m, changed;
  logic          cx_first, cx_last, cy_first;

  logic [COUNT_W-1:0] chg_acc_q, alv_acc_q;
  logic [COUNT_W-1:0] last_chg_q, last_alv_q;

  // cell access
  logic [AW-1:0] cell_addr;
  logic          cell_in_area;
  logic          rd_hit_q;
  logic          rd_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic          wr_data, wr_cur, wr_a, wr_b;

  logic          read_value_q;
  logic [COUNT_W-1:0] change_q, alive_q;

  assign cell_addr = AW'(cell_y_i) * AW'(MAX_WIDTH) + AW'(cell_x_i);
  assign cell_in_area = (32'(cell_x_i) < 32'(grid_width_q)) && (32'(cell_x_i) < MAX_WIDTH)
                     && (32'(cell_y_i) < 32'(grid_height_q)) && (32'(cell_y_i) < MAX_HEIGHT);

  assign pad_a    = (s_q >= CW'(NCELL));
  assign inarea_a = !pad_a && (32'(sx_q) < 32'(grid_width_q))
                 && (32'(sy_q) < 32'(grid_height_q));

  assign rd_en   = cmd_i.cell_rd || rd_run_q;
  assign rd_addr = rd_run_q ? (pad_a ? '0 : s_q[AW-1:0]) : cell_addr;

  // one write per bank per cycle: cell write or clear on the current bank,
  // sweep results on the other one
  assign wr_cur  = cmd_i.clear_en || (cmd_i.cell_wr && cell_in_area);
  assign wr_addr = cmd_i.cell_wr ? cell_addr : c_idx_q;
  assign wr_data = cmd_i.cell_wr ? cell_value_i : (win_v_q && next_m);
  assign wr_a    = (wr_cur && !cur_q) || (win_v_q && cur_q);
  assign wr_b    = (wr_cur && cur_q) || (win_v_q && !cur_q);

  always_ff @(posedge clk_i) begin
    if (wr_a) mem_a_q[wr_addr] <= wr_data;
    if (rd_en) rdata_a_q <= mem_a_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (wr_b) mem_b_q[wr_addr] <= wr_data;
    if (rd_en) rdata_b_q <= mem_b_q[rd_addr];
  end

  assign src_bit = cur_q ? rdata_b_q : rdata_a_q;

  // 3x3 window out of the line buffer; sr_q[k] holds cell (newest - k)
  assign cx_first = (cx_q == '0);
  assign cx_last  = (cx_q == XW'(MAX_WIDTH - 1));
  assign cy_first = (cy_q == '0);

  for (genvar g = 0; g < 8; g++) begin : g_nbr
    localparam int TAP = int'(CENTER) - NBR_DY[g] * int'(MAX_WIDTH) - NBR_DX[g];
    localparam bit IS_LEFT  = (NBR_DX[g] < 0);
    localparam bit IS_RIGHT = (NBR_DX[g] > 0);
    localparam bit IS_TOP   = (NBR_DY[g] < 0);
    // row-wrap and stale-top taps are dead
    assign nb[g] = sr_q[TAP] && !((IS_LEFT && cx_first) || (IS_RIGHT && cx_last)
                                  || (IS_TOP && cy_first));
  end

  always_comb begin
    nsum = '0;
    for (int i = 0; i < 8; i++) begin
      nsum = nsum + {3'b000, nb[i]};
    end
  end

  assign cur_c   = sr_q[CENTER];
  assign cin     = (32'(cx_q) < 32'(grid_width_q)) && (32'(cy_q) < 32'(grid_height_q));
  assign next_m  = cin && ((nsum == 4'd3) || (cur_c && (nsum == 4'd2)));
  assign changed = next_m ^ cur_c;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= GRID_RESET;
      grid_height_q <= GRID_RESET;
      cur_q         <= 1'b0;
      rd_run_q      <= 1'b0;
      s_q           <= '0;
      sx_q          <= '0;
      sy_q          <= '0;
      vb_q          <= 1'b0;
      inb_q         <= 1'b0;
      emitb_q       <= 1'b0;
      win_v_q       <= 1'b0;
      c_idx_q       <= '0;
      cx_q          <= '0;
      cy_q          <= '0;
      sweep_last_q  <= 1'b0;
      chg_acc_q     <= '0;
      alv_acc_q     <= '0;
      last_chg_q    <= '0;
      last_alv_q    <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          CFG_GRID_WIDTH:  grid_width_q <= cfg_data_i;
          CFG_GRID_HEIGHT: grid_height_q <= cfg_data_i;
          default:         ;
        endcase
      end

      // read stage
      if (cmd_i.sweep_start) begin
        rd_run_q <= 1'b1;
        s_q      <= '0;
        sx_q     <= '0;
        sy_q     <= '0;
      end else if (rd_run_q) begin
        if (s_q == CW'(S_LAST)) rd_run_q <= 1'b0;
        s_q <= s_q + CW'(1);
        if (sx_q == XW'(MAX_WIDTH - 1)) begin
          sx_q <= '0;
          sy_q <= sy_q + YW'(1);
        end else begin
          sx_q <= sx_q + XW'(1);
        end
      end

      // shift stage
      vb_q    <= rd_run_q;
      inb_q   <= inarea_a;
      emitb_q <= rd_run_q && (s_q >= CW'(S_EMIT));
      win_v_q <= vb_q && emitb_q;

      // update stage and clearing pass share the center index
      sweep_last_q <= win_v_q && (c_idx_q == AW'(NCELL - 1));
      if (cmd_i.sweep_start) begin
        c_idx_q   <= '0;
        cx_q      <= '0;
        cy_q      <= '0;
        chg_acc_q <= '0;
        alv_acc_q <= '0;
      end else if (win_v_q || cmd_i.clear_en) begin
        c_idx_q <= (c_idx_q == AW'(NCELL - 1)) ? '0 : c_idx_q + AW'(1);
        if (cx_q == XW'(MAX_WIDTH - 1)) begin
          cx_q <= '0;
          cy_q <= cy_q + YW'(1);
        end else begin
          cx_q <= cx_q + XW'(1);
        end
        if (win_v_q && changed && (chg_acc_q != COUNT_MAX)) begin
          chg_acc_q <= chg_acc_q + COUNT_W'(1);
        end
        if (win_v_q && next_m && (alv_acc_q != COUNT_MAX)) begin
          alv_acc_q <= alv_acc_q + COUNT_W'(1);
        end
      end

      // commit the generation
      if (sweep_last_q) begin
        last_chg_q <= chg_acc_q;
        last_alv_q <= alv_acc_q;
        cur_q      <= ~cur_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (vb_q) sr_q <= {sr_q[SR_LEN-2:0], src_bit && inb_q};
    if (cmd_i.accept) rd_hit_q <= cmd_i.cell_rd && cell_in_area;
    if (cmd_i.out_load) begin
      read_value_q <= rd_hit_q && src_bit;
      change_q     <= last_chg_q;
      alive_q      <= last_alv_q;
    end
  end

  assign status_o.clear_done = cmd_i.clear_en && (c_idx_q == AW'(NCELL - 1));
  assign status_o.sweep_done = sweep_last_q;

  assign read_value_o   = read_value_q;
  assign change_count_o = change_q;
  assign alive_count_o  = alive_q;

  `LGE_ASSERT_IMPL(a_no_cell_wr_in_sweep, clk_i, rst_ni, cmd_i.cell_wr,
                   !rd_run_q && !vb_q && !win_v_q)
  `LGE_ASSERT(a_drained_at_commit, clk_i, rst_ni,
              sweep_last_q |-> (!rd_run_q && !vb_q && !win_v_q))
  `LGE_ASSERT(a_bank_swaps_after_commit, clk_i, rst_ni,
              sweep_last_q |=> (cur_q != $past(cur_q)))

endmodule

>>> design/life_generation_engine.sv
// ----------------------------------------------------------------------------
// life_generation_engine
// B3/S23 cellular automaton on a bounded, non-wrapping grid held in two banks.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+---------------------------------
//   in      | input     | in_valid_i / in_stall_o    | kind, cell_x, cell_y, cell_value
//   out     | output    | out_valid_o / out_stall_i  | read_value, change/alive count
//   cfg     | input     | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// Cell write, cell read and unused kinds: the result is registered in the post
// state once the result register is free; the next item is taken after that. A
// generation sweeps one cell per cycle through the single read port of the
// source bank.
// After reset a clearing pass over MAX_WIDTH*MAX_HEIGHT cells zeroes bank a;
// in_stall_o stays high meanwhile, cfg writes are taken at any time.
// One item is in flight; the next is taken while a result beat waits on stall.
// ----------------------------------------------------------------------------
module life_generation_engine
  import lge_pkg::*;
#(
  parameter int unsigned MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [KIND_W-1:0]    kind_i,
  input  logic [COORD_W-1:0]   cell_x_i,
  input  logic [COORD_W-1:0]   cell_y_i,
  input  logic                 cell_value_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 read_value_o,
  output logic [COUNT_W-1:0]   change_count_o,
  output logic [COUNT_W-1:0]   alive_count_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  cmd_t    cmd;
  status_t status;

  assign cfg_ready_o = 1'b1;

  lge_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .kind_i      (kind_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  lge_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cell_x_i       (cell_x_i),
    .cell_y_i       (cell_y_i),
    .cell_value_i   (cell_value_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .read_value_o   (read_value_o),
    .change_count_o (change_count_o),
    .alive_count_o  (alive_count_o)
  );

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Checks the life generation engine against a cycle-free model of the B3/S23
// grid. A directed table covers reset, corners, lone cells, a blinker and two
// corner blocks. Random phases follow, each setting a grid size, from empty
// to oversized. Both handshakes idle at random, and one long output hold-off
// is included.
// ----------------------------------------------------------------------------
module testbench
  import lge_pkg::*;
;

  localparam int unsigned GRID_CELLS  = DEF_MAX_WIDTH * DEF_MAX_HEIGHT;
  localparam int unsigned CYCLE_LIMIT = 3000000;
  localparam int unsigned NUM_PHASES  = 10;
  localparam int unsigned PHASE_ITEMS = 11;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic               v;
  } cell_op_t;

  typedef struct packed {
    logic               rd;
    logic [COUNT_W-1:0] changes;
    logic [COUNT_W-1:0] alive;
  } life_result_t;

  typedef struct packed {
    cell_op_t     op;
    logic         typed;
    life_result_t res;
  } stim_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [KIND_W-1:0]    kind_i;
  logic [COORD_W-1:0]   cell_x_i;
  logic [COORD_W-1:0]   cell_y_i;
  logic                 cell_value_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic                 read_value_o;
  logic [COUNT_W-1:0]   change_count_o;
  logic [COUNT_W-1:0]   alive_count_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_data_i;

  life_generation_engine u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .kind_i         (kind_i),
    .cell_x_i       (cell_x_i),
    .cell_y_i       (cell_y_i),
    .cell_value_i   (cell_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .read_value_o   (read_value_o),
    .change_count_o (change_count_o),
    .alive_count_o  (alive_count_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // model state
  bit                 life_bank [2][GRID_CELLS];
  bit                 cur_sel;
  logic [COUNT_W-1:0] last_chg;
  logic [COUNT_W-1:0] last_live;
  logic [CFG_W-1:0]   cfg_w;
  logic [CFG_W-1:0]   cfg_h;

  life_result_t expected_beats [$];
  life_result_t got_beat;
  life_result_t want_beat;
  int unsigned  fail_cnt;
  int unsigned  cycle_cnt;
  bit           no_idle;
  bit           hold_req;
  int           win_ox, win_oy, win_w, win_h;

  stim_row_t        dir_tab [24];
  logic [CFG_W-1:0] ph_w [NUM_PHASES];
  logic [CFG_W-1:0] ph_h [NUM_PHASES];

  function automatic int used_span(logic [CFG_W-1:0] v, int lim);
    return (v > lim) ? lim : int'(v);
  endfunction

  function automatic life_result_t predict_cell_op(cell_op_t op);
    life_result_t res;
    int w, h, x, y, nx, ny, n, idx;
    bit in_area, src, dst, cur, nxt;
    logic [COUNT_W-1:0] chg, live;
    w = used_span(cfg_w, DEF_MAX_WIDTH);
    h = used_span(cfg_h, DEF_MAX_HEIGHT);
    in_area = (int'(op.x) < w) && (int'(op.y) < h);
    idx = int'(op.y) * DEF_MAX_WIDTH + int'(op.x);
    res.rd = 1'b0;
    case (op.kind)
      KIND_WRITE: begin
        if (in_area) life_bank[cur_sel][idx] = op.v;
      end
      KIND_GEN: begin
        src = cur_sel;
        dst = !cur_sel;
        for (int i = 0; i < GRID_CELLS; i++) life_bank[dst][i] = 1'b0;
        chg = '0;
        live = '0;
        for (y = 0; y < h; y++) begin
          for (x = 0; x < w; x++) begin
            n = 0;
            for (int dy = -1; dy <= 1; dy++) begin
              for (int dx = -1; dx <= 1; dx++) begin
                nx = x + dx;
                ny = y + dy;
                if ((dx != 0 || dy != 0) && nx >= 0 && ny >= 0 && nx < w && ny < h)
                  n += life_bank[src][ny * DEF_MAX_WIDTH + nx];
              end
            end
            cur = life_bank[src][y * DEF_MAX_WIDTH + x];
            nxt = (n == 3) || (cur && n == 2);
            life_bank[dst][y * DEF_MAX_WIDTH + x] = nxt;
            if (nxt != cur && chg != COUNT_MAX) chg++;
            if (nxt && live != COUNT_MAX) live++;
          end
        end
        last_chg = chg;
        last_live = live;
        cur_sel = dst;
      end
      KIND_READ: begin
        if (in_area) res.rd = life_bank[cur_sel][idx];
      end
      default: ;
    endcase
    res.changes = last_chg;
    res.alive = last_live;
    return res;
  endfunction

  function automatic stim_row_t mk(logic [KIND_W-1:0] k, int x, int y, bit v, bit typed,
                                   bit rd, int chg, int alv);
    stim_row_t r;
    r.op.kind = k;
    r.op.x = COORD_W'(x);
    r.op.y = COORD_W'(y);
    r.op.v = v;
    r.typed = typed;
    r.res.rd = rd;
    r.res.changes = COUNT_W'(chg);
    r.res.alive = COUNT_W'(alv);
    return r;
  endfunction

  // mostly short, now and then long
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(1, 2);
    if (r < 90) return $urandom_range(3, 8);
    return $urandom_range(20, 60);
  endfunction

  // most ops land in a small window so patterns actually evolve
  function automatic cell_op_t rand_op();
    cell_op_t op;
    int r;
    r = $urandom_range(0, 99);
    op.x = COORD_W'($urandom_range(0, 63));
    op.y = COORD_W'($urandom_range(0, 63));
    op.v = 1'($urandom_range(0, 1));
    if (win_w > 0 && win_h > 0 && $urandom_range(0, 9) < 8) begin
      op.x = COORD_W'(win_ox + $urandom_range(0, win_w - 1));
      op.y = COORD_W'(win_oy + $urandom_range(0, win_h - 1));
    end
    if (r < 45) begin
      op.kind = KIND_WRITE;
      op.v = ($urandom_range(0, 9) < 6);
    end else if (r < 60) begin
      op.kind = KIND_GEN;
    end else if (r < 92) begin
      op.kind = KIND_READ;
    end else begin
      op.kind = KIND_UNUSED;
    end
    return op;
  endfunction

  // entered and left at a falling edge
  task automatic send_op(input cell_op_t op, input bit typed, input life_result_t typed_res);
    int gap;
    life_result_t pred;
    gap = (no_idle || $urandom_range(0, 1)) ? 0 : gap_len();
    if (gap > 0) begin
      in_valid_i = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    kind_i = op.kind;
    cell_x_i = op.x;
    cell_y_i = op.y;
    cell_value_i = op.v;
    in_valid_i = 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    pred = predict_cell_op(op);
    expected_beats.push_back(typed ? typed_res : pred);
    @(negedge clk_i);
  endtask

  task automatic settle();
    in_valid_i = 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_index_i = idx;
    cfg_data_i = val;
    cfg_valid_i = 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == CFG_GRID_WIDTH) cfg_w = val;
    else cfg_h = val;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Regression FAIL");
    $finish;
  end

  // receiver: random stall runs, one long hold-off on request
  initial begin
    int run;
    int hold_left;
    run = 0;
    hold_left = 0;
    out_stall_i = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        out_stall_i = 1'b1;
        hold_left--;
      end else if (no_idle) begin
        out_stall_i = 1'b0;
      end else begin
        if (run == 0) begin
          if ($urandom_range(0, 1)) begin
            out_stall_i = 1'b0;
            run = $urandom_range(1, 6);
          end else begin
            out_stall_i = 1'b1;
            run = gap_len();
          end
        end
        run--;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got_beat.rd = read_value_o;
      got_beat.changes = change_count_o;
      got_beat.alive = alive_count_o;
      if (expected_beats.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= 10)
          $display("unexpected result beat: rd=%0d chg=%0d alive=%0d",
                   got_beat.rd, got_beat.changes, got_beat.alive);
      end else begin
        want_beat = expected_beats.pop_front();
        if (got_beat.rd !== want_beat.rd || got_beat.changes !== want_beat.changes ||
            got_beat.alive !== want_beat.alive) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("result mismatch: exp rd=%0d chg=%0d alive=%0d, got rd=%0d chg=%0d alive=%0d",
                     want_beat.rd, want_beat.changes, want_beat.alive,
                     got_beat.rd, got_beat.changes, got_beat.alive);
        end
      end
    end
  end

  initial begin
    cell_op_t op;
    fail_cnt = 0;
    no_idle = 1'b0;
    hold_req = 1'b0;
    win_ox = 0;
    win_oy = 0;
    win_w = 0;
    win_h = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    kind_i = KIND_WRITE;
    cell_x_i = '0;
    cell_y_i = '0;
    cell_value_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_GRID_WIDTH;
    cfg_data_i = '0;

    for (int i = 0; i < GRID_CELLS; i++) begin
      life_bank[0][i] = 1'b0;
      life_bank[1][i] = 1'b0;
    end
    cur_sel = 1'b0;
    last_chg = '0;
    last_live = '0;
    cfg_w = GRID_RESET;
    cfg_h = GRID_RESET;

    dir_tab = '{
      mk(KIND_READ,    0,  0, 1'b0, 1'b1, 1'b0, 0, 0),
      mk(KIND_READ,   63, 63, 1'b0, 1'b1, 1'b0, 0, 0),
      mk(KIND_WRITE,  63, 63, 1'b1, 1'b1, 1'b0, 0, 0),
      mk(KIND_READ,   63, 63, 1'b0, 1'b1, 1'b1, 0, 0),
      mk(KIND_WRITE,   0,  0, 1'b1, 1'b1, 1'b0, 0, 0),
      mk(KIND_UNUSED, 63, 63, 1'b1, 1'b1, 1'b0, 0, 0),
      // two lone cells die
      mk(KIND_GEN,     0,  0, 1'b0, 1'b1, 1'b0, 2, 0),
      mk(KIND_READ,   63, 63, 1'b0, 1'b1, 1'b0, 2, 0),
      // blinker
      mk(KIND_WRITE,  10,  5, 1'b1, 1'b0, 1'b0, 0, 0),
      mk(KIND_WRITE,  11,  5, 1'b1, 1'b0, 1'b0, 0, 0),
      mk(KIND_WRITE,  12,  5, 1'b1, 1'b0, 1'b0, 0, 0),
      mk(KIND_GEN,     0,  0, 1'b0, 1'b0, 1'b0, 0, 0),
      mk(KIND_READ,   11,  4, 1'b0, 1'b0, 1'b0, 0, 0),
      mk(KIND_READ,   11,  6, 1'b0, 1'b0, 1'b0, 0, 0),
      mk(KIND_GEN,     0,  0, 1'b0, 1'b0, 1'b0, 0, 0),
      mk(KIND_READ,   12,  5, 1'b0, 1'b0, 1'b0, 0, 0),
      // L shapes in two corners grow into blocks
      mk(KIND_WRITE,   0, 63, 1'b1, 1'b0, 1'b0, 0, 0),
      mk(KIND_WRITE,   1, 63, 1'b1, 1'b0, 1'b0, 0, 0),
      mk(KIND_WRITE,   0, 62, 1'b1, 1'b0, 1'b0, 0, 0),
      mk(KIND_WRITE,  63,  0, 1'b1, 1'b0, 1'b0, 0, 0),
      mk(KIND_WRITE,  62,  0, 1'b1, 1'b0, 1'b0, 0, 0),
      mk(KIND_WRITE,  63,  1, 1'b1, 1'b0, 1'b0, 0, 0),
      mk(KIND_GEN,     0,  0, 1'b0, 1'b0, 1'b0, 0, 0),
      mk(KIND_READ,    1, 62, 1'b0, 1'b0, 1'b0, 0, 0)
    };

    ph_w = '{7'd64, 7'd16, 7'd64, 7'd1, 7'd0, 7'd5, 7'd127, 7'd3, 7'd64, 7'd8};
    ph_h = '{7'd64, 7'd10, 7'd64, 7'd1, 7'd5, 7'd0, 7'd127, 7'd64, 7'd3, 7'd8};

    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // the first beat waits out the clearing pass behind in_stall_o
    foreach (dir_tab[r]) send_op(dir_tab[r].op, dir_tab[r].typed, dir_tab[r].res);

    for (int p = 0; p < NUM_PHASES; p++) begin
      settle();
      write_reg(CFG_GRID_WIDTH, ph_w[p]);
      write_reg(CFG_GRID_HEIGHT, ph_h[p]);
      win_w = used_span(ph_w[p], DEF_MAX_WIDTH);
      win_h = used_span(ph_h[p], DEF_MAX_HEIGHT);
      if (win_w > 6) win_w = 6;
      if (win_h > 6) win_h = 6;
      win_ox = $urandom_range(0, used_span(ph_w[p], DEF_MAX_WIDTH) - win_w);
      win_oy = $urandom_range(0, used_span(ph_h[p], DEF_MAX_HEIGHT) - win_h);
      no_idle = (p == 2 || p == 7);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (p == 0 && i == 4) begin
          // output held off while reads keep coming: the block backs up
          hold_req = 1'b1;
          no_idle = 1'b1;
          repeat (8) begin
            op = rand_op();
            op.kind = KIND_READ;
            send_op(op, 1'b0, '0);
          end
          no_idle = 1'b0;
        end
        if (p == 3 && i == 7) settle();
        send_op(rand_op(), 1'b0, '0);
      end
    end

    settle();
    repeat (50) @(posedge clk_i);
    if (fail_cnt == 0 && expected_beats.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
